[rtl/npp_pkg.sv]
`default_nettype none

package npp_pkg;

    localparam int VALUE_BITS_DEFAULT = 24;
    localparam int LIMIT_BITS         = 24;
    localparam int INDEX_BITS         = 16;
    localparam int DIV_BITS           = LIMIT_BITS / 2 + 1;
    localparam int DSQ_BITS           = 2 * DIV_BITS;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1000000);
    localparam logic [DIV_BITS-1:0]   FIRST_DIVISOR = DIV_BITS'(2);

    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_status_t;

endpackage

`default_nettype wire

[rtl/npp_query_if.sv]
`default_nettype none

interface npp_query_if
    import npp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] start_value;
    logic [VALUE_BITS-1:0] step_value;
    logic [INDEX_BITS-1:0] wanted_index;

    modport source (
        output valid,
        output start_value,
        output step_value,
        output wanted_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_value,
        input  step_value,
        input  wanted_index,
        output ready
    );
endinterface

`default_nettype wire

[rtl/npp_answer_if.sv]
`default_nettype none

interface npp_answer_if
    import npp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [LIMIT_BITS-1:0] prime_value;
    logic                  found;

    modport source (
        output valid,
        output prime_value,
        output found,
        input  ready
    );

    modport sink (
        input  valid,
        input  prime_value,
        input  found,
        output ready
    );
endinterface

`default_nettype wire

[rtl/npp_rem_unit.sv]
`default_nettype none

module npp_rem_unit
    import npp_pkg::*;
#(
    parameter int DIVIDEND_BITS = LIMIT_BITS,
    parameter int DIVISOR_BITS  = DIV_BITS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output div_status_t                   status
);
    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);
    localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(DIVIDEND_BITS - 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [DIVIDEND_BITS-1:0] dividend_reg;
    logic [DIVISOR_BITS-1:0]  divisor_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;

    logic [DIVISOR_BITS:0]    shifted;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;
    logic [DIVISOR_BITS-1:0]  rem_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted  = {rem_reg, dividend_reg[DIVIDEND_BITS-1]};
        diff     = shifted - {1'b0, divisor_reg};
        fits     = shifted >= {1'b0, divisor_reg};
        rem_next = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= dividend;
            divisor_reg  <= divisor;
            rem_reg      <= '0;
        end
        else if (busy_reg)
        begin
            dividend_reg <= {dividend_reg[DIVIDEND_BITS-2:0], 1'b0};
            rem_reg      <= rem_next;
        end
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

`default_nettype wire

[rtl/nth_prime_in_progression.sv]
// Per candidate, the sequencer runs trial division by each divisor d with d*d <= candidate
//   on the shared bit-serial remainder unit, moving on at the first zero remainder.
// Throughput: one query at a time, and the remainder unit sets the pace of each query.
// A query with wanted_index zero goes straight to the finish state with no search.
// Reset: sequencer idle, no answer pending, search_limit back to 1000000.
`default_nettype none

module nth_prime_in_progression
    import npp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [LIMIT_BITS-1:0] cfg_wdata,
    npp_query_if.sink                  query,
    npp_answer_if.source               answer
);
    localparam int CAND_BITS = ((VALUE_BITS > LIMIT_BITS) ? VALUE_BITS : LIMIT_BITS) + 1;
    localparam int CMP_BITS  = (CAND_BITS > DSQ_BITS) ? CAND_BITS : DSQ_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TEST,
        S_DIVIDE,
        S_NEXT,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [CAND_BITS-1:0]  cand_reg, cand_next;
    logic [VALUE_BITS-1:0] step_reg, step_next;
    logic [INDEX_BITS-1:0] remain_reg, remain_next;
    logic [DIV_BITS-1:0]   d_reg, d_next;
    logic [DSQ_BITS-1:0]   dsq_reg, dsq_next;
    logic [LIMIT_BITS-1:0] res_value_reg, res_value_next;
    logic                  res_found_reg, res_found_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LIMIT_BITS-1:0] prime_reg, prime_next;
    logic                  found_reg, found_next;

    logic                  div_start;
    div_status_t           div_st;
    logic                  slot_free;
    logic                  past_limit;
    logic                  below_two;
    logic                  sq_over;

    assign slot_free  = !out_valid_reg || answer.ready;
    assign past_limit = cand_reg >= CAND_BITS'(limit_reg);
    assign below_two  = cand_reg < CAND_BITS'(2);
    assign sq_over    = CMP_BITS'(dsq_reg) > CMP_BITS'(cand_reg);
    assign div_start  = (state_reg == S_TEST) && !sq_over;

    npp_rem_unit #(
        .DIVIDEND_BITS (LIMIT_BITS),
        .DIVISOR_BITS  (DIV_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cand_reg[LIMIT_BITS-1:0]),
        .divisor  (d_reg),
        .status   (div_st)
    );

    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        step_next      = step_reg;
        remain_next    = remain_reg;
        d_next         = d_reg;
        dsq_next       = dsq_reg;
        res_value_next = res_value_reg;
        res_found_next = res_found_reg;
        out_valid_next = out_valid_reg && !answer.ready;
        prime_next     = prime_reg;
        found_next     = found_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (query.valid)
                begin
                    cand_next      = CAND_BITS'(query.start_value);
                    step_next      = query.step_value;
                    remain_next    = query.wanted_index;
                    res_value_next = '0;
                    res_found_next = 1'b0;
                    state_next     = (query.wanted_index == '0) ? S_FINISH : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (past_limit)
                begin
                    state_next = S_FINISH;
                end
                else if (below_two)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    d_next     = FIRST_DIVISOR;
                    dsq_next   = DSQ_BITS'(FIRST_DIVISOR) * DSQ_BITS'(FIRST_DIVISOR);
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (sq_over)
                begin
                    if (remain_reg == INDEX_BITS'(1))
                    begin
                        res_value_next = cand_reg[LIMIT_BITS-1:0];
                        res_found_next = 1'b1;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        remain_next = remain_reg - 1'b1;
                        state_next  = S_NEXT;
                    end
                end
                else
                begin
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (div_st.done)
                begin
                    if (div_st.rem_zero)
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        dsq_next   = dsq_reg + DSQ_BITS'({d_reg, 1'b1});
                        d_next     = d_reg + 1'b1;
                        state_next = S_TEST;
                    end
                end
            end
            S_NEXT:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cand_next  = cand_reg + CAND_BITS'(step_reg);
                    state_next = S_CHECK;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    prime_next     = res_value_reg;
                    found_next     = res_found_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            cand_reg      <= '0;
            step_reg      <= '0;
            remain_reg    <= '0;
            d_reg         <= '0;
            dsq_reg       <= '0;
            res_value_reg <= '0;
            res_found_reg <= 1'b0;
            prime_reg     <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cand_reg      <= cand_next;
            step_reg      <= step_next;
            remain_reg    <= remain_next;
            d_reg         <= d_next;
            dsq_reg       <= dsq_next;
            res_value_reg <= res_value_next;
            res_found_reg <= res_found_next;
            prime_reg     <= prime_next;
            found_reg     <= found_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    assign query.ready        = (state_reg == S_IDLE);
    assign answer.valid       = out_valid_reg;
    assign answer.prime_value = prime_reg;
    assign answer.found       = found_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (query.valid && query.ready) |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after a query beat");

    a_test_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST) |-> (!past_limit && !below_two))
        else $error("trial division on a candidate out of range");

    a_square_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST) |-> (dsq_reg == DSQ_BITS'(d_reg) * DSQ_BITS'(d_reg)))
        else $error("divisor square out of step with divisor");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIVIDE))
        else $error("remainder unit finished outside the divide state");

endmodule

`default_nettype wire

[tb/tb_nth_prime_in_progression.sv]
`timescale 1ns / 100ps

module tb_nth_prime_in_progression;
    import npp_pkg::*;

    localparam int          VALUE_BITS     = VALUE_BITS_DEFAULT;
    localparam int unsigned DIV_CYCLES     = LIMIT_BITS + 2;
    localparam int unsigned CAND_CYCLES    = 4;
    localparam int unsigned WORK_BUDGET    = 40000;
    localparam int unsigned HOLD_CYCLES    = 3000;
    localparam int unsigned IDLE_SETTLE    = 8;
    localparam int unsigned WATCHDOG_LIMIT = 500000;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] prime_value;
        logic                  found;
    } answer_t;

    typedef enum int unsigned {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_e;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [LIMIT_BITS-1:0] cfg_wdata;

    npp_query_if #(.VALUE_BITS(VALUE_BITS)) query_bus ();
    npp_answer_if                           answer_bus ();

    nth_prime_in_progression #(
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .query     (query_bus),
        .answer    (answer_bus)
    );

    logic [LIMIT_BITS-1:0] limit_shadow = LIMIT_RESET;
    answer_t               pending_answers[$];
    answer_t               oldest_answer;

    int unsigned failures        = 0;
    int unsigned queries_sent    = 0;
    int unsigned answers_checked = 0;
    int unsigned primes_seen     = 0;
    int unsigned limits_used     = 1;

    int unsigned burst_left   = 0;
    bit          sender_quiet = 1'b0;

    rx_mode_e    rx_mode       = RX_ALWAYS;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned stall_tick    = 0;
    int unsigned quiet_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void note_failure(input string what);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    function automatic answer_t predict_nth_prime(
        input  logic [VALUE_BITS-1:0] start,
        input  logic [VALUE_BITS-1:0] step,
        input  logic [INDEX_BITS-1:0] want,
        output int unsigned           work
    );
        answer_t         result;
        longint unsigned cand;
        longint unsigned divisor;
        int unsigned     left;
        bit              cand_prime;
        result = '0;
        work   = 2;
        if (want == '0)
            return result;
        cand = 64'(start);
        left = 32'(want);
        while (cand < limit_shadow)
        begin
            work += CAND_CYCLES;
            cand_prime = (cand >= 2);
            divisor    = 2;
            while (cand_prime && divisor * divisor <= cand)
            begin
                work += DIV_CYCLES;
                if (cand % divisor == 0)
                    cand_prime = 1'b0;
                divisor++;
            end
            if (cand_prime)
            begin
                left--;
                if (left == 0)
                begin
                    result.prime_value = cand[LIMIT_BITS-1:0];
                    result.found       = 1'b1;
                    break;
                end
            end
            if (step == '0)
                break;
            cand += 64'(step);
        end
        return result;
    endfunction

    task automatic send_query(
        input logic [VALUE_BITS-1:0] start,
        input logic [VALUE_BITS-1:0] step,
        input logic [INDEX_BITS-1:0] want
    );
        answer_t     expected;
        int unsigned work;
        int unsigned gap;
        expected = predict_nth_prime(start, step, want, work);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = sender_quiet ? 0 : $urandom_range(0, 12);
            if (gap != 0)
            begin
                query_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        query_bus.valid        <= 1'b1;
        query_bus.start_value  <= start;
        query_bus.step_value   <= step;
        query_bus.wanted_index <= want;
        do
            @(posedge clk);
        while (query_bus.ready !== 1'b1);
        pending_answers.push_back(expected);
        queries_sent++;
    endtask

    // drop valid and let the last answer drain before touching the limit
    task automatic wait_idle();
        query_bus.valid <= 1'b0;
        burst_left = 0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic set_search_limit(input logic [LIMIT_BITS-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_shadow = value;
        limits_used++;
    endtask

    task automatic random_queries(
        input int unsigned count,
        input int unsigned max_want,
        input int unsigned max_step
    );
        logic [VALUE_BITS-1:0] start;
        logic [VALUE_BITS-1:0] step;
        logic [INDEX_BITS-1:0] want;
        int unsigned           work;
        int unsigned           pick;
        repeat (count)
        begin
            do
            begin
                pick  = $urandom_range(0, 9);
                start = VALUE_BITS'($urandom_range(0, limit_shadow - 1));
                step  = VALUE_BITS'($urandom_range(1, max_step));
                want  = INDEX_BITS'($urandom_range(1, max_want));
                if (pick == 0)
                begin
                    start = VALUE_BITS'($urandom());
                    step  = VALUE_BITS'($urandom());
                    want  = INDEX_BITS'($urandom());
                end
                else if (pick == 1)
                begin
                    if ($urandom_range(0, 1) == 0)
                        step = '0;
                    else
                        want = '0;
                end
                else if (pick == 2)
                    step = VALUE_BITS'($urandom());
                void'(predict_nth_prime(start, step, want, work));
            end
            while (work > WORK_BUDGET);
            send_query(start, step, want);
        end
    endtask

    task automatic test_default_limit();
        rx_mode      = RX_PATTERN;
        sender_quiet = 1'b0;
        send_query(24'd5,       24'd1,        16'd0);
        send_query(24'd0,       24'd0,        16'd0);
        send_query(24'd0,       24'd1,        16'd1);
        send_query(24'd1,       24'd2,        16'd3);
        send_query(24'd2,       24'd1,        16'd5);
        send_query(24'd97,      24'd0,        16'd1);
        send_query(24'd97,      24'd0,        16'd2);
        send_query(24'd91,      24'd0,        16'd1);
        send_query(24'd999983,  24'd1,        16'd1);
        send_query(24'd999984,  24'd1,        16'd1);
        send_query(24'd1000000, 24'd1,        16'd1);
        send_query(24'd999990,  24'd1,        16'hFFFF);
        send_query(24'd3,       24'hFFFFFF,   16'd2);
        send_query(24'hFFFFFF,  24'hFFFFFF,   16'hFFFF);
    endtask

    task automatic test_limit_extremes();
        rx_mode = RX_RANDOM;
        set_search_limit(24'hFFFFFF);
        send_query(24'd16777213, 24'd2,       16'd1);
        send_query(24'd16777210, 24'hFFFFFF,  16'd2);
        send_query(24'hFFFFFF,   24'd1,       16'd1);
        set_search_limit(24'd2);
        send_query(24'd0,        24'd1,       16'd1);
        send_query(24'd2,        24'd1,       16'd1);
        set_search_limit(24'd1);
        send_query(24'd0,        24'd1,       16'd1);
        send_query(24'd1,        24'd0,       16'd1);
        set_search_limit(24'd3);
        send_query(24'd0,        24'd1,       16'd1);
        send_query(24'd0,        24'd1,       16'd2);
    endtask

    task automatic test_random_search();
        set_search_limit(24'd97);
        rx_mode      = RX_RANDOM;
        sender_quiet = 1'b0;
        random_queries(25, 30, 20);
        set_search_limit(24'd1000);
        rx_mode = RX_PATTERN;
        random_queries(25, 8, 40);
        set_search_limit(LIMIT_BITS'($urandom_range(5000, 30000)));
        rx_mode      = RX_ALWAYS;
        sender_quiet = 1'b1;
        random_queries(25, 3, 200);
    endtask

    // hold the answer side while queries keep coming so the block backs up
    task automatic test_answer_backpressure();
        set_search_limit(24'd200);
        rx_mode      = RX_ALWAYS;
        sender_quiet = 1'b1;
        hold_requests++;
        random_queries(15, 4, 10);
        rx_mode      = RX_RANDOM;
        sender_quiet = 1'b0;
        random_queries(10, 6, 10);
    endtask

    always @(posedge clk)
    begin
        stall_tick++;
        if (hold_left != 0)
        begin
            answer_bus.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES - 1;
            answer_bus.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_RANDOM:  answer_bus.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: answer_bus.ready <= ((stall_tick % 9) < 6);
                default:    answer_bus.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && answer_bus.valid === 1'b1 && answer_bus.ready === 1'b1)
        begin
            if (pending_answers.size() == 0)
                note_failure($sformatf("answer beat with nothing pending: prime_value=%0d found=%0b",
                                       answer_bus.prime_value, answer_bus.found));
            else
            begin
                oldest_answer = pending_answers.pop_front();
                answers_checked++;
                if (answer_bus.prime_value !== oldest_answer.prime_value)
                    note_failure($sformatf("prime_value: expected %0d, got %0d",
                                           oldest_answer.prime_value, answer_bus.prime_value));
                if (answer_bus.found !== oldest_answer.found)
                    note_failure($sformatf("found: expected %0b, got %0b",
                                           oldest_answer.found, answer_bus.found));
                if (oldest_answer.found)
                    primes_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((query_bus.valid === 1'b1 && query_bus.ready === 1'b1) ||
            (answer_bus.valid === 1'b1 && answer_bus.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no beat on either channel for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        query_bus.valid        = 1'b0;
        query_bus.start_value  = '0;
        query_bus.step_value   = '0;
        query_bus.wanted_index = '0;
        answer_bus.ready       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_limit();
        test_limit_extremes();
        test_random_search();
        test_answer_backpressure();

        wait_idle();
        repeat (20) @(posedge clk);
        if (pending_answers.size() != 0)
            note_failure($sformatf("%0d answers never arrived", pending_answers.size()));

        $display("Ran %0d queries over %0d search limits; %0d answers checked, %0d primes found.",
                 queries_sent, limits_used, answers_checked, primes_seen);
        $display("Sender bursts and gaps, three receiver stall modes and one long answer hold.");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
rtl/npp_pkg.sv
rtl/npp_query_if.sv
rtl/npp_answer_if.sv
rtl/npp_rem_unit.sv
rtl/nth_prime_in_progression.sv
tb/tb_nth_prime_in_progression.sv
